>>> design/assert_macros.svh
// Assertion macros used by the checker file of the histogram block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ISH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define ISH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ish_pkg.sv
// Types, codes and constants of the integer statistics histogram block.
package ish_pkg;

   // Default number of histogram bins.
   localparam int ISH_MAX_BINS = 256;

   // Divider widths: wide dividend, 32-bit divisor, bit counter.
   localparam int DIV_W = 112;
   localparam int DVS_W = 32;
   localparam int LEN_W = 7;

   // Shift-add multiplier widths.
   localparam int MCAND_W = 64;
   localparam int MPLIER_W = 48;
   localparam int PROD_W = 96;

   // Width of the bin count before clamping.
   localparam int NBR_W = 18;

   // Configuration port address width.
   localparam int CSR_AW = 4;

   // Input modes; the spare code is handled as a read.
   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_READ = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_SAT = 2'd1;
   localparam logic [1:0] STATUS_NOBIN = 2'd2;

   // Register indexes.
   localparam logic [1:0] REG_RANGE_MIN = 2'd0;
   localparam logic [1:0] REG_RANGE_MAX = 2'd1;
   localparam logic [1:0] REG_BIN_STEP = 2'd2;

   // Divider launch control.
   typedef struct packed {
      logic start;
      logic [LEN_W-1:0] len;
   } div_ctl_type;

endpackage

>>> design/ish_div.sv
// Restoring divider that produces one quotient bit per cycle.
module ish_div
   import ish_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DVS_W-1:0]  divisor,
   output logic [DIV_W-1:0]  quotient,
   output logic [DVS_W-1:0]  remainder,
   output logic              done
);

   logic [DIV_W-1:0] work_ff, work_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic             qbit;

   // One shift-and-subtract step per cycle; the dividend is left aligned.
   always_comb begin
      trial = {rem_ff, work_ff[DIV_W-1]};
      qbit = (trial >= {1'b0, dvs_ff});
      work_in = work_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         work_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = ctl.len;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[DIV_W-2:0], qbit};
         rem_in = qbit ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         cnt_in = cnt_ff - LEN_W'(1);
         if (cnt_ff == LEN_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = work_ff;
   assign remainder = rem_ff;
   assign done = done_ff;

endmodule

>>> design/ish_mul.sv
// Shift-add multiplier that handles one multiplier bit per cycle.
module ish_mul
   import ish_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MCAND_W-1:0]  mcand,
   input  logic [MPLIER_W-1:0] mplier,
   output logic [PROD_W-1:0]   product,
   output logic                done
);

   localparam int CNT_W = $clog2(MPLIER_W + 1);

   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [PROD_W-1:0]   mc_ff, mc_in;
   logic [MPLIER_W-1:0] mp_ff, mp_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   // Add the shifted multiplicand for each set multiplier bit.
   always_comb begin
      acc_in = acc_ff;
      mc_in = mc_ff;
      mp_in = mp_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mc_in = PROD_W'(mcand);
         mp_in = mplier;
         cnt_in = CNT_W'(MPLIER_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in = {mc_ff[PROD_W-2:0], 1'b0};
         mp_in = {1'b0, mp_ff[MPLIER_W-1:1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff <= mc_in;
      mp_ff <= mp_in;
   end

   assign product = acc_ff;
   assign done = done_ff;

endmodule

>>> design/ish_bins.sv
// Bin count memory: one write port and one registered read port.
module ish_bins #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [31:0]              wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [31:0]              rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/integer_stats_histogram_top.sv
// Top level of the integer statistics histogram block.
//
//  Channel  Direction  Handshake                 Payload
//  req      in         req_tvalid / req_tready   tuser mode, tdata sample, read_bin
//  rsp      out        rsp_tvalid / rsp_tready   tuser status, tdata results
//  csr      in         APB write / read          range_min, range_max, bin_step
//
// One transaction at a time; how long an add or a read takes is set by the
// serial divider (span, bin index, mean, three variance steps) and the shift-add multiplier.
// After reset and on a clear, a pass writes zero to all MAX_BINS memory entries, one a cycle,
// while req_tready stays low; configuration writes are taken at any time.
// A finished result waits in the output register while the next request is accepted.
module integer_stats_histogram_top
   import ish_pkg::*;
#(
   parameter int MAX_BINS = ISH_MAX_BINS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // sample[15:0], read_bin[23:16]
   input  logic [1:0]        req_tuser,   // mode[1:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [151:0]      rsp_tdata,   // bin_hit[7:0], bin_value[39:8],
                                          // obs_count[71:40], mean_fixed[103:72],
                                          // mean_var_fixed[151:104]
   output logic [1:0]        rsp_tuser,   // status[1:0]
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int ADDR_W = $clog2(MAX_BINS);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SPAN  = 4'd2;
   localparam logic [3:0] S_SPANW = 4'd3;
   localparam logic [3:0] S_CLASS = 4'd4;
   localparam logic [3:0] S_IDXW  = 4'd5;
   localparam logic [3:0] S_RD    = 4'd6;
   localparam logic [3:0] S_RDW   = 4'd7;
   localparam logic [3:0] S_MEAN  = 4'd8;
   localparam logic [3:0] S_MEANW = 4'd9;
   localparam logic [3:0] S_MUL1W = 4'd10;
   localparam logic [3:0] S_MUL2W = 4'd11;
   localparam logic [3:0] S_VD1W  = 4'd12;
   localparam logic [3:0] S_VD2W  = 4'd13;
   localparam logic [3:0] S_VD3W  = 4'd14;
   localparam logic [3:0] S_OUT   = 4'd15;

   logic [3:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic               pend_ff, pend_in;
   logic               is_add_ff, is_add_in;
   logic [15:0]        sample_ff, sample_in;
   logic [7:0]         rb_ff, rb_in;
   logic [31:0]        count_ff, count_in;
   logic [47:0]        sum_ff, sum_in;
   logic [63:0]        ss_ff, ss_in;
   logic [NBR_W-1:0]   nb_ff, nb_in;
   logic [NBR_W-1:0]   idx_ff, idx_in;
   logic [7:0]         hit_ff, hit_in;
   logic [31:0]        val_ff, val_in;
   logic [1:0]         status_ff, status_in;
   logic [31:0]        mean_ff, mean_in;
   logic [47:0]        var_ff, var_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [15:0]        rmin_ff, rmax_ff, step_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [151:0]       rsp_data_ff;
   logic [1:0]         rsp_user_ff;

   div_ctl_type        div_ctl;
   logic [DIV_W-1:0]   div_dividend, div_quotient;
   logic [DVS_W-1:0]   div_divisor, div_remainder;
   logic               div_done;
   logic               mul_start, mul_done;
   logic [MCAND_W-1:0] mul_mcand;
   logic [MPLIER_W-1:0] mul_mplier;
   logic [PROD_W-1:0]  mul_product;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [31:0]        ram_wdata, ram_rdata;

   logic               req_fire, cfg_write, out_free;
   logic signed [17:0] span;
   logic [15:0]        sample_v;
   logic signed [31:0] square;
   logic [47:0]        mag;
   logic [15:0]        offset;
   logic [NBR_W-1:0]   nb_raw, idx_raw;
   logic [PROD_W-1:0]  diff;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign sample_v = req_tdata[15:0];
   assign square = $signed(sample_v) * $signed(sample_v);
   assign span = 18'(signed'({rmax_ff[15], rmax_ff})) - 18'(signed'({rmin_ff[15], rmin_ff}))
               + 18'sd1;
   assign mag = sum_ff[47] ? 48'(-sum_ff) : sum_ff;
   assign offset = 16'(sample_ff - rmin_ff);
   assign nb_raw = NBR_W'(div_quotient[16:0]) + NBR_W'(2) + NBR_W'(div_remainder != '0);
   assign idx_raw = NBR_W'(div_quotient[15:0]) + NBR_W'(1);
   assign diff = prod_ff - mul_product;

   // Configuration registers and read-back.
   assign csr_pready = 1'b1;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rmin_ff <= 16'd0;
         rmax_ff <= 16'd253;
         step_ff <= 16'd1;
      end else if (cfg_write) begin
         unique case (csr_paddr[3:2])
            REG_RANGE_MIN: rmin_ff <= csr_pwdata[15:0];
            REG_RANGE_MAX: rmax_ff <= csr_pwdata[15:0];
            REG_BIN_STEP:  step_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_RANGE_MIN: csr_prdata = {16'd0, rmin_ff};
         REG_RANGE_MAX: csr_prdata = {16'd0, rmax_ff};
         REG_BIN_STEP:  csr_prdata = {16'd0, step_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // Sequencer: memory clear, statistics update, bin lookup, then mean and variance.
   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      pend_in = pend_ff;
      is_add_in = is_add_ff;
      sample_in = sample_ff;
      rb_in = rb_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      ss_in = ss_ff;
      nb_in = nb_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      val_in = val_ff;
      status_in = status_ff;
      mean_in = mean_ff;
      var_in = var_ff;
      prod_in = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      div_ctl = '{start: 1'b0, len: '0};
      div_dividend = '0;
      div_divisor = '0;
      mul_start = 1'b0;
      mul_mcand = '0;
      mul_mplier = '0;
      ram_we = 1'b0;
      ram_waddr = sweep_ff;
      ram_wdata = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            sweep_in = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(MAX_BINS - 1)) begin
               sweep_in = '0;
               state_in = pend_ff ? S_MEAN : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               pend_in = 1'b1;
               sample_in = sample_v;
               rb_in = req_tdata[23:16];
               hit_in = '0;
               val_in = '0;
               status_in = STATUS_OK;
               is_add_in = 1'b0;
               case (req_tuser)
                  MODE_CLEAR: begin
                     count_in = '0;
                     sum_in = '0;
                     ss_in = '0;
                     state_in = S_CLEAR;
                  end
                  MODE_ADD: begin
                     if (count_ff == '1) begin
                        status_in = STATUS_SAT;
                        state_in = S_MEAN;
                     end else begin
                        count_in = count_ff + 32'd1;
                        sum_in = sum_ff + {{32{sample_v[15]}}, sample_v};
                        ss_in = ss_ff + 64'(unsigned'(square));
                        is_add_in = 1'b1;
                        if (step_ff == '0) begin
                           status_in = STATUS_NOBIN;
                           state_in = S_MEAN;
                        end else begin
                           state_in = S_SPAN;
                        end
                     end
                  end
                  default: begin
                     hit_in = req_tdata[23:16];
                     if (step_ff == '0) begin
                        status_in = STATUS_NOBIN;
                        state_in = S_MEAN;
                     end else begin
                        state_in = S_SPAN;
                     end
                  end
               endcase
            end
         end
         S_SPAN: begin
            if (span <= 18'sd0) begin
               nb_in = NBR_W'(2);
               state_in = S_CLASS;
            end else begin
               div_ctl = '{start: 1'b1, len: LEN_W'(17)};
               div_dividend = {span[16:0], {(DIV_W-17){1'b0}}};
               div_divisor = {16'd0, step_ff};
               state_in = S_SPANW;
            end
         end
         S_SPANW: begin
            if (div_done) begin
               nb_in = (nb_raw > NBR_W'(MAX_BINS)) ? NBR_W'(MAX_BINS) : nb_raw;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            if (is_add_ff) begin
               if ($signed(sample_ff) > $signed(rmax_ff)) begin
                  idx_in = nb_ff - NBR_W'(1);
                  state_in = S_RD;
               end else if ($signed(sample_ff) < $signed(rmin_ff)) begin
                  idx_in = '0;
                  state_in = S_RD;
               end else begin
                  div_ctl = '{start: 1'b1, len: LEN_W'(16)};
                  div_dividend = {offset, {(DIV_W-16){1'b0}}};
                  div_divisor = {16'd0, step_ff};
                  state_in = S_IDXW;
               end
            end else if (NBR_W'(rb_ff) >= nb_ff) begin
               status_in = STATUS_NOBIN;
               state_in = S_MEAN;
            end else begin
               idx_in = NBR_W'(rb_ff);
               state_in = S_RD;
            end
         end
         S_IDXW: begin
            if (div_done) begin
               idx_in = (idx_raw > nb_ff - NBR_W'(2)) ? nb_ff - NBR_W'(2) : idx_raw;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_RDW;
         end
         S_RDW: begin
            if (is_add_ff) begin
               ram_we = 1'b1;
               ram_waddr = idx_ff[ADDR_W-1:0];
               ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + 32'd1;
               val_in = ram_wdata;
               hit_in = idx_ff[7:0];
            end else begin
               val_in = ram_rdata;
            end
            state_in = S_MEAN;
         end
         S_MEAN: begin
            if (count_ff == '0) begin
               mean_in = '0;
               var_in = '0;
               state_in = S_OUT;
            end else begin
               div_ctl = '{start: 1'b1, len: LEN_W'(64)};
               div_dividend = {mag, 16'd0, {(DIV_W-64){1'b0}}};
               div_divisor = count_ff;
               state_in = S_MEANW;
            end
         end
         S_MEANW: begin
            if (div_done) begin
               mean_in = sum_ff[47] ? 32'(-div_quotient[31:0]) : div_quotient[31:0];
               if (count_ff < 32'd2) begin
                  var_in = '0;
                  state_in = S_OUT;
               end else begin
                  mul_start = 1'b1;
                  mul_mcand = ss_ff;
                  mul_mplier = {16'd0, count_ff};
                  state_in = S_MUL1W;
               end
            end
         end
         S_MUL1W: begin
            if (mul_done) begin
               prod_in = mul_product;
               mul_start = 1'b1;
               mul_mcand = {16'd0, mag};
               mul_mplier = mag;
               state_in = S_MUL2W;
            end
         end
         S_MUL2W: begin
            if (mul_done) begin
               if (prod_ff < mul_product) begin
                  var_in = '0;
                  state_in = S_OUT;
               end else begin
                  div_ctl = '{start: 1'b1, len: LEN_W'(DIV_W)};
                  div_dividend = {diff, 16'd0};
                  div_divisor = count_ff;
                  state_in = S_VD1W;
               end
            end
         end
         S_VD1W: begin
            if (div_done) begin
               div_ctl = '{start: 1'b1, len: LEN_W'(DIV_W)};
               div_dividend = div_quotient;
               div_divisor = count_ff;
               state_in = S_VD2W;
            end
         end
         S_VD2W: begin
            if (div_done) begin
               div_ctl = '{start: 1'b1, len: LEN_W'(DIV_W)};
               div_dividend = div_quotient;
               div_divisor = count_ff - 32'd1;
               state_in = S_VD3W;
            end
         end
         S_VD3W: begin
            if (div_done) begin
               var_in = (div_quotient[DIV_W-1:48] != '0) ? '1 : div_quotient[47:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pend_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and statistics registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sweep_ff <= '0;
         pend_ff <= 1'b0;
         count_ff <= '0;
         sum_ff <= '0;
         ss_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         pend_ff <= pend_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         ss_ff <= ss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_add_ff <= is_add_in;
      sample_ff <= sample_in;
      rb_ff <= rb_in;
      nb_ff <= nb_in;
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      val_ff <= val_in;
      status_ff <= status_in;
      mean_ff <= mean_in;
      var_ff <= var_in;
      prod_ff <= prod_in;
   end

   // Output register, loaded once the result is complete.
   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         rsp_data_ff <= {var_ff, mean_ff, count_ff, val_ff, hit_ff};
         rsp_user_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   ish_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .done      (div_done)
   );

   ish_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .product (mul_product),
      .done    (mul_done)
   );

   ish_bins #(
      .DEPTH (MAX_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

endmodule

>>> design/ish_checker.sv
// Port-level checker of the histogram block and its bind to the top level.
`include "assert_macros.svh"

module ish_checker
   import ish_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [151:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         csr_pready
);

   // A result transaction stays offered until it is taken.
   `ISH_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped")

   // A stalled result keeps its payload.
   `ISH_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "rsp payload changed")

   // The configuration port never waits.
   `ISH_ASSERT_ALWAYS(a_pready, clock, csr_pready, "pready low")

   // Status carries one of the three defined codes.
   `ISH_ASSERT(a_status_code, clock, reset, rsp_tvalid |-> rsp_tuser != 2'd3, "bad status")

   // A saturated sample reports no bin index and no bin value.
   `ISH_ASSERT(a_sat_empty, clock, reset, rsp_tvalid && rsp_tuser == STATUS_SAT |-> rsp_tdata[39:0] == 40'd0, "saturated result carries a bin")

endmodule

bind integer_stats_histogram_top ish_checker u_ish_checker (.*);
